[hw/rtl/cea_pkg.sv]
// Shared types and constants of the contiguous extent allocator.
// Used by the top level, cea_alu and cea_seq; depends on nothing.
package cea_pkg;

	localparam int IDX_BITS    = 4;
	localparam int SIZE_BITS   = 32;
	localparam int BLK_BITS    = 16;
	localparam int BLOCK_BYTES = 512;
	localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);
	// blocks needed for a 32-bit byte count, rounded up
	localparam int NBLK_BITS   = SIZE_BITS - BLK_SHIFT + 1;
	// end of a run: block sum plus needed blocks, never wraps
	localparam int LIM_BITS    = ((BLK_BITS + 1 > NBLK_BITS) ? BLK_BITS + 1 : NBLK_BITS) + 1;
	localparam int ALU_W       = SIZE_BITS + 2;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_NO_SPACE   = 2'd1,
		STAT_TABLE_FULL = 2'd2,
		STAT_BAD_INDEX  = 2'd3
	} status_t;

	typedef enum logic {
		MODE_CREATE = 1'b0,
		MODE_GROW   = 1'b1
	} mode_t;

	typedef struct packed {
		logic                 mode;
		logic [IDX_BITS-1:0]  file_index;
		logic [SIZE_BITS-1:0] new_size;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [IDX_BITS-1:0]  entry_index;
		logic [BLK_BITS-1:0]  first_block;
		logic [BLK_BITS-1:0]  block_count;
		logic [SIZE_BITS-1:0] byte_size;
	} rsp_t;

	typedef struct packed {
		logic [BLK_BITS-1:0]  start;
		logic [BLK_BITS-1:0]  blocks;
		logic [SIZE_BITS-1:0] bytes;
	} entry_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] res;
		logic             ge;
	} alu_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CUR,
		S_FIT,
		S_NBLK,
		S_BASE,
		S_LIM,
		S_SC_A,
		S_SC_B,
		S_END1,
		S_END2,
		S_DONE
	} state_t;

endpackage

[hw/rtl/cea_stream_if.sv]
// Valid/ready stream channel with a typed payload.
// Payload types come from cea_pkg at the point of instantiation.
interface cea_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/contiguous_extent_allocator_top.sv]
// Top level of the contiguous extent allocator: config register, result
// register, and the sequencer, ALU and table RAM. Depends on cea_pkg,
// cea_stream_if, cea_ram, cea_alu and cea_seq.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+----------------------------------------------
//   req     | in  | valid/ready       | mode, file_index, new_size
//   rsp     | out | valid/ready       | status, entry_index, first_block,
//           |     |                   | block_count, byte_size
//   cfg     | in  | cfg_we (no stall) | cfg_wdata = partition_blocks
//
// A create, a table-full or a bad-index request goes from idle straight to
// done. A grow that needs no new blocks stops after the size check or the
// last-block fit check; one that places or extends a run scans the table:
// each entry costs one RAM read and two passes through the shared ALU.
// One request is in flight at a time; req.ready is high only while idle.
// The result register lets the next request in while rsp is stalled.
// Reset clears the entry count and partition_blocks; no clearing pass.
module contiguous_extent_allocator_top #(
	parameter int MAX_FILES  = 16,
	parameter int DIR_BLOCKS = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	cea_stream_if.sink                   req,
	cea_stream_if.source                 rsp,
	input  logic                         cfg_we,
	input  logic [cea_pkg::BLK_BITS-1:0] cfg_wdata
);
	import cea_pkg::*;

	localparam int AW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;

	logic [BLK_BITS-1:0] partition_q;
	logic                out_vld_q;
	rsp_t                out_q;
	rsp_t                res;
	logic                done;
	logic                take;
	alu_req_t            alu_req;
	alu_rsp_t            alu_rsp;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	entry_t              ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	entry_t              ram_rdata;

	assign take        = !out_vld_q || rsp.ready;
	assign rsp.valid   = out_vld_q;
	assign rsp.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partition_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				partition_q <= cfg_wdata;
			end
			if (done && take) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done && take) begin
			out_q <= res;
		end
	end

	cea_seq #(
		.MAX_FILES  (MAX_FILES),
		.DIR_BLOCKS (DIR_BLOCKS),
		.AW         (AW)
	) u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.partition_blocks (partition_q),
		.req              (req),
		.res              (res),
		.done             (done),
		.take             (take),
		.alu_req          (alu_req),
		.alu_rsp          (alu_rsp),
		.ram_we           (ram_we),
		.ram_waddr        (ram_waddr),
		.ram_wdata        (ram_wdata),
		.ram_re           (ram_re),
		.ram_raddr        (ram_raddr),
		.ram_rdata        (ram_rdata)
	);

	cea_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	cea_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_FILES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// one transaction in flight: no new request the cycle after one is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while a previous one is in flight");

	// a finished result always lands in the result register
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(done && take) |=> (rsp.valid && rsp.payload == $past(res)))
		else $error("finished result not loaded into the output register");

	// a completed result never sits in the sequencer while the output is free
	a_no_idle_done: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !out_vld_q) |=> !done)
		else $error("sequencer held its result with the output register empty");

	// rejected requests report no extent
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (res.status == STAT_BAD_INDEX || res.status == STAT_TABLE_FULL)) |->
		(res.first_block == '0 && res.block_count == '0 && res.byte_size == '0))
		else $error("rejected request carries extent data");
endmodule

[hw/rtl/cea_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cea_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[hw/rtl/cea_alu.sv]
// Shared add/subtract unit; its carry flag gives unsigned greater-or-equal on a subtract.
// Depends on cea_pkg for the request and response structs.
module cea_alu (
	input  cea_pkg::alu_req_t req,
	output cea_pkg::alu_rsp_t rsp
);
	import cea_pkg::*;

	logic [ALU_W-1:0] b_op;
	logic [ALU_W:0]   full;

	always_comb begin
		b_op = (req.op == ALU_SUB) ? ~req.b : req.b;
		full = {1'b0, req.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, (req.op == ALU_SUB)};
		rsp.res = full[ALU_W-1:0];
		// carry out of a - b is set when a >= b
		rsp.ge  = full[ALU_W];
	end
endmodule

[hw/rtl/cea_seq.sv]
// Sequencer and working registers: decodes a transaction, walks the extent
// table through the RAM and drives the shared ALU. Depends on cea_pkg.
module cea_seq #(
	parameter int MAX_FILES  = 16,
	parameter int DIR_BLOCKS = 2,
	parameter int AW         = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cea_pkg::BLK_BITS-1:0]  partition_blocks,
	cea_stream_if.sink                    req,
	output cea_pkg::rsp_t                 res,
	output logic                          done,
	input  logic                          take,
	output cea_pkg::alu_req_t             alu_req,
	input  cea_pkg::alu_rsp_t             alu_rsp,
	output logic                          ram_we,
	output logic [AW-1:0]                 ram_waddr,
	output cea_pkg::entry_t               ram_wdata,
	output logic                          ram_re,
	output logic [AW-1:0]                 ram_raddr,
	input  cea_pkg::entry_t               ram_rdata
);
	import cea_pkg::*;

	localparam int TW = $clog2(MAX_FILES + 1);

	state_t               state_q, state_nx;
	logic [TW-1:0]        total_q;
	logic [TW-1:0]        k_q;
	logic [TW-1:0]        k_nx;
	logic [IDX_BITS-1:0]  idx_q;
	logic [SIZE_BITS-1:0] size_q;
	logic [SIZE_BITS-1:0] need_q;
	logic [NBLK_BITS-1:0] nblk_q;
	logic [BLK_BITS:0]    acc_q;
	logic [LIM_BITS-1:0]  lim_q;
	logic [BLK_BITS-1:0]  newblk_q;
	logic                 ge1_q;
	entry_t               cur_q;
	entry_t               ent_q;
	rsp_t                 res_q;

	logic                 in_acc;
	logic                 in_range;
	logic                 full;
	logic                 is_empty;
	logic                 no_grow;
	logic                 fits;
	logic                 overlap;
	logic                 last;
	logic [BLK_SHIFT-1:0] lo;
	logic [BLK_SHIFT-1:0] left;
	rsp_t                 fail_res;

	assign in_acc   = req.valid && req.ready;
	assign in_range = req.payload.file_index < total_q;
	assign full     = total_q == TW'(MAX_FILES);
	assign is_empty = cur_q.bytes == '0;
	assign no_grow  = !alu_rsp.ge || (alu_rsp.res == '0);
	assign lo       = cur_q.bytes[BLK_SHIFT-1:0];
	// free bytes in the last block when it is partly used
	assign left     = (~lo) + BLK_SHIFT'(1);
	assign fits     = (lo != '0) && alu_rsp.ge;
	assign overlap  = !is_empty && ge1_q && !alu_rsp.ge;
	assign k_nx     = k_q + TW'(1);
	assign last     = k_nx == total_q;
	assign res      = res_q;

	always_comb begin
		fail_res             = '0;
		fail_res.status      = STAT_NO_SPACE;
		fail_res.entry_index = idx_q;
		fail_res.first_block = cur_q.start;
		fail_res.block_count = cur_q.blocks;
		fail_res.byte_size   = cur_q.bytes;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_nx = (req.payload.mode == MODE_GROW && in_range) ? S_CUR : S_DONE;
				end
			end
			S_CUR:  state_nx = no_grow ? S_DONE : S_FIT;
			S_FIT:  state_nx = fits ? S_DONE : S_NBLK;
			S_NBLK: state_nx = S_BASE;
			S_BASE: state_nx = S_LIM;
			S_LIM:  state_nx = S_SC_A;
			S_SC_A: state_nx = S_SC_B;
			S_SC_B: begin
				if (overlap) begin
					state_nx = S_DONE;
				end else if (last) begin
					state_nx = S_END1;
				end else begin
					state_nx = S_SC_A;
				end
			end
			S_END1: state_nx = S_END2;
			S_END2: state_nx = S_DONE;
			S_DONE: begin
				if (take) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// outputs: ALU operands, RAM ports, handshake
	always_comb begin
		alu_req   = '{op: ALU_ADD, a: '0, b: '0};
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		req.ready = 1'b0;
		done      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				ram_re    = req.valid;
				ram_raddr = AW'(req.payload.file_index);
				if (req.valid && req.payload.mode == MODE_CREATE && !full) begin
					ram_we    = 1'b1;
					ram_waddr = total_q[AW-1:0];
				end
			end
			S_CUR: begin
				alu_req = '{op: ALU_SUB, a: ALU_W'(size_q), b: ALU_W'(ram_rdata.bytes)};
			end
			S_FIT: begin
				alu_req   = '{op: ALU_SUB, a: ALU_W'(left), b: ALU_W'(need_q)};
				ram_we    = fits;
				ram_waddr = AW'(idx_q);
				ram_wdata = '{start: cur_q.start, blocks: cur_q.blocks, bytes: size_q};
			end
			S_NBLK: begin
				alu_req = '{op: ALU_ADD, a: ALU_W'(need_q), b: ALU_W'(BLOCK_BYTES - 1)};
			end
			S_BASE: begin
				alu_req = '{op: ALU_ADD, a: ALU_W'(cur_q.start), b: ALU_W'(cur_q.blocks)};
			end
			S_LIM: begin
				alu_req   = '{op: ALU_ADD, a: ALU_W'(acc_q), b: ALU_W'(nblk_q)};
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			S_SC_A: begin
				alu_req = '{op: ALU_SUB, a: ALU_W'(ram_rdata.start), b: ALU_W'(acc_q)};
			end
			S_SC_B: begin
				if (is_empty) begin
					alu_req = '{op: ALU_ADD, a: ALU_W'(ent_q.start), b: ALU_W'(ent_q.blocks)};
				end else begin
					alu_req = '{op: ALU_SUB, a: ALU_W'(ent_q.start), b: ALU_W'(lim_q)};
				end
				ram_re    = !last;
				ram_raddr = k_nx[AW-1:0];
			end
			S_END1: begin
				if (is_empty) begin
					alu_req = '{op: ALU_ADD, a: ALU_W'(acc_q), b: ALU_W'(nblk_q)};
				end else begin
					alu_req = '{op: ALU_ADD, a: ALU_W'(cur_q.blocks), b: ALU_W'(nblk_q)};
				end
			end
			S_END2: begin
				alu_req   = '{op: ALU_SUB, a: ALU_W'(lim_q), b: ALU_W'(partition_blocks)};
				ram_we    = !alu_rsp.ge;
				ram_waddr = AW'(idx_q);
				if (is_empty) begin
					ram_wdata = '{start: acc_q[BLK_BITS-1:0], blocks: nblk_q[BLK_BITS-1:0],
						bytes: size_q};
				end else begin
					ram_wdata = '{start: cur_q.start, blocks: newblk_q, bytes: size_q};
				end
			end
			S_DONE: begin
				done = 1'b1;
			end
			default: begin
				done = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
		end else begin
			state_q <= state_nx;
			if (in_acc && req.payload.mode == MODE_CREATE && !full) begin
				total_q <= total_q + TW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					idx_q  <= req.payload.file_index;
					size_q <= req.payload.new_size;
					if (req.payload.mode == MODE_CREATE) begin
						if (full) begin
							res_q <= '{status: STAT_TABLE_FULL, entry_index: '0,
								first_block: '0, block_count: '0, byte_size: '0};
						end else begin
							res_q <= '{status: STAT_OK, entry_index: IDX_BITS'(total_q),
								first_block: '0, block_count: '0, byte_size: '0};
						end
					end else if (!in_range) begin
						res_q <= '{status: STAT_BAD_INDEX,
							entry_index: req.payload.file_index,
							first_block: '0, block_count: '0, byte_size: '0};
					end else begin
						res_q <= '0;
					end
				end
			end
			S_CUR: begin
				cur_q  <= ram_rdata;
				need_q <= (ram_rdata.bytes == '0) ? size_q : alu_rsp.res[SIZE_BITS-1:0];
				if (no_grow) begin
					res_q <= '{status: STAT_OK, entry_index: idx_q, first_block: ram_rdata.start,
						block_count: ram_rdata.blocks, byte_size: ram_rdata.bytes};
				end
			end
			S_FIT: begin
				if (fits) begin
					res_q <= '{status: STAT_OK, entry_index: idx_q, first_block: cur_q.start,
						block_count: cur_q.blocks, byte_size: size_q};
				end
			end
			S_NBLK: begin
				nblk_q <= alu_rsp.res[SIZE_BITS:BLK_SHIFT];
			end
			S_BASE: begin
				acc_q <= is_empty ? (BLK_BITS + 1)'(DIR_BLOCKS) : alu_rsp.res[BLK_BITS:0];
			end
			S_LIM: begin
				lim_q <= alu_rsp.res[LIM_BITS-1:0];
				k_q   <= '0;
			end
			S_SC_A: begin
				ent_q <= ram_rdata;
				ge1_q <= alu_rsp.ge;
			end
			S_SC_B: begin
				// empty file: hop past every extent at or after the candidate
				if (is_empty && ge1_q) begin
					acc_q <= alu_rsp.res[BLK_BITS:0];
				end
				k_q <= k_nx;
				if (overlap) begin
					res_q <= fail_res;
				end
			end
			S_END1: begin
				if (is_empty) begin
					lim_q <= alu_rsp.res[LIM_BITS-1:0];
				end else begin
					newblk_q <= alu_rsp.res[BLK_BITS-1:0];
				end
			end
			S_END2: begin
				if (alu_rsp.ge) begin
					res_q <= fail_res;
				end else if (is_empty) begin
					res_q <= '{status: STAT_OK, entry_index: idx_q,
						first_block: acc_q[BLK_BITS-1:0], block_count: nblk_q[BLK_BITS-1:0],
						byte_size: size_q};
				end else begin
					res_q <= '{status: STAT_OK, entry_index: idx_q, first_block: cur_q.start,
						block_count: newblk_q, byte_size: size_q};
				end
			end
			S_DONE: begin
				res_q <= res_q;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end
endmodule
